FILE: design/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

	// most characters one item can cause
	localparam int MaxOut = 12;
	localparam int CntW   = $clog2(MaxOut + 1);

	// item kinds carried on the input tuser
	typedef enum logic [1:0] {
		MODE_OPEN  = 2'd0,
		MODE_BYTE  = 2'd1,
		MODE_CLOSE = 2'd2,
		MODE_NULL  = 2'd3
	} mode_t;

	// word index of the unicode escape enable register
	localparam logic RegEscape = 1'b0;

	// ascii characters used in the emitted text
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChN      = 8'h6E;
	localparam logic [7:0] ChR      = 8'h72;
	localparam logic [7:0] ChT      = 8'h74;
	localparam logic [7:0] ChU      = 8'h75;
	localparam logic [7:0] ChL      = 8'h6C;

	// replacement character and surrogate bases
	localparam logic [15:0] CpReplace = 16'hFFFD;
	localparam logic [20:0] CpPlane1  = 21'h10000;
	localparam logic [15:0] SurrHigh  = 16'hD800;
	localparam logic [15:0] SurrLow   = 16'hDC00;

	// characters of one item, entry 0 goes out first
	typedef logic [MaxOut-1:0][7:0] char_vec_t;

	// characters and their number for one item
	typedef struct packed {
		char_vec_t        chars;
		logic [CntW-1:0]  count;
	} plan_t;

	// utf-8 decoder state
	typedef struct packed {
		logic [1:0]  pend;
		logic [20:0] acc;
	} dec_state_t;

	// uppercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = 8'h30 + {4'b0, nib};
		end else begin
			ch = 8'h37 + {4'b0, nib};
		end
		return ch;
	endfunction

	// six characters of a \uXXXX escape, backslash in entry 0
	function automatic logic [5:0][7:0] u16_chars(input logic [15:0] v);
		logic [5:0][7:0] c;
		c[0] = ChBslash;
		c[1] = ChU;
		c[2] = hex_char(v[15:12]);
		c[3] = hex_char(v[11:8]);
		c[4] = hex_char(v[7:4]);
		c[5] = hex_char(v[3:0]);
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// Converts string events and UTF-8 content bytes into escaped JSON text.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: s_axis_tuser is the item kind (open, byte, close, null),
//   s_axis_tdata the content byte. Output stream: one text character per
//   transfer on m_axis_tdata, m_axis_tlast on the final character of an input
//   item. Items that emit nothing (utf-8 lead and middle bytes) produce no
//   output at all.
//   The APB port holds the unicode escape enable at address 0; write it only
//   while the block is idle.
// Flow
//   An accepted item sits in the input register and is decoded into the
//   result register once that register is free; its first character is
//   then valid. An item that emits n characters (n up to 12) holds the
//   result register until its final character is taken, while the input
//   register can already hold the next item. Single-character items stream
//   at one per cycle as long as the receiver does not stall.
// Reset and stall
//   Reset empties both registers, clears the utf-8 decoder and turns unicode
//   escaping on. When the receiver stalls, the current character holds
//   and the input register fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // byte_in[7:0]
	input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // char_out[7:0]
	output logic             m_axis_tlast,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [7:0]           byte_s1;
	logic                 escape_q;
	jse_pkg::dec_state_t  state_q;
	jse_pkg::dec_state_t  state_nxt;
	jse_pkg::plan_t       plan;
	logic                 free;
	logic                 advance;
	logic                 in_take;

	assign pready        = 1'b1;
	assign advance       = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == jse_pkg::RegEscape) begin
			escape_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == jse_pkg::RegEscape) ? {31'b0, escape_q} : '0;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// utf-8 decoder state, moves with each item handed to the emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	jse_decode u_decode (
		.mode       (mode_s1),
		.byte_in    (byte_s1),
		.unicode_en (escape_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.plan       (plan)
	);

	jse_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_req      (valid_s1),
		.plan          (plan),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: design/jse_decode.sv
// ----------------------------------------------------------------------------
// jse_decode
// Turns one registered item and the decoder state into the characters it
// causes and the next decoder state.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_decode (
	input  wire logic [1:0]          mode,
	input  wire logic [7:0]          byte_in,
	input  wire logic                unicode_en,
	input  wire jse_pkg::dec_state_t cur,
	output jse_pkg::dec_state_t      nxt,
	output jse_pkg::plan_t           plan
);

	jse_pkg::char_vec_t    body;
	logic [jse_pkg::CntW-1:0] body_cnt;
	logic                  flush;
	logic                  is_cont;
	logic [20:0]           acc_cont;
	logic [1:0]            pend_dec;
	logic [20:0]           cp_off;
	logic [15:0]           hi_unit;
	logic [15:0]           lo_unit;
	jse_pkg::mode_t        kind;

	assign kind     = jse_pkg::mode_t'(mode);
	assign acc_cont = {cur.acc[14:0], byte_in[5:0]};
	assign pend_dec = cur.pend - 2'd1;
	assign is_cont  = (kind == jse_pkg::MODE_BYTE) && (cur.pend != 2'd0) &&
		unicode_en && (byte_in[7:6] == 2'b10);

	// surrogate pair halves of the finished code point
	assign cp_off  = acc_cont - jse_pkg::CpPlane1;
	assign hi_unit = jse_pkg::SurrHigh + {5'b0, cp_off[20:10]};
	assign lo_unit = jse_pkg::SurrLow + {6'b0, cp_off[9:0]};

	// body text and next state
	always_comb begin
		body     = '0;
		body_cnt = '0;
		flush    = 1'b0;
		nxt      = cur;
		if (is_cont) begin
			nxt.pend = pend_dec;
			if (pend_dec == 2'd0) begin
				nxt.acc = '0;
				if (acc_cont >= jse_pkg::CpPlane1) begin
					body[5:0]  = jse_pkg::u16_chars(hi_unit);
					body[11:6] = jse_pkg::u16_chars(lo_unit);
					body_cnt   = 4'd12;
				end else begin
					body[5:0] = jse_pkg::u16_chars(acc_cont[15:0]);
					body_cnt  = 4'd6;
				end
			end else begin
				nxt.acc = acc_cont;
			end
		end else begin
			// pending sequence broken or unfinished
			flush    = (cur.pend != 2'd0);
			nxt.pend = 2'd0;
			nxt.acc  = '0;
			case (kind)
				jse_pkg::MODE_BYTE: begin
					if (!byte_in[7]) begin
						body_cnt = 4'd2;
						body[0]  = jse_pkg::ChBslash;
						case (byte_in)
							jse_pkg::ChQuote:  body[1] = jse_pkg::ChQuote;
							jse_pkg::ChBslash: body[1] = jse_pkg::ChBslash;
							jse_pkg::ChLf:     body[1] = jse_pkg::ChN;
							jse_pkg::ChCr:     body[1] = jse_pkg::ChR;
							jse_pkg::ChTab:    body[1] = jse_pkg::ChT;
							default: begin
								body[0]  = byte_in;
								body_cnt = 4'd1;
							end
						endcase
					end else if (!unicode_en) begin
						body[0]  = byte_in;
						body_cnt = 4'd1;
					end else if (byte_in[7:5] == 3'b110) begin
						nxt.acc  = {16'b0, byte_in[4:0]};
						nxt.pend = 2'd1;
					end else if (byte_in[7:4] == 4'b1110) begin
						nxt.acc  = {17'b0, byte_in[3:0]};
						nxt.pend = 2'd2;
					end else if (byte_in[7:3] == 5'b11110) begin
						nxt.acc  = {18'b0, byte_in[2:0]};
						nxt.pend = 2'd3;
					end else begin
						body[5:0] = jse_pkg::u16_chars(jse_pkg::CpReplace);
						body_cnt  = 4'd6;
					end
				end
				jse_pkg::MODE_NULL: begin
					body[0]  = jse_pkg::ChN;
					body[1]  = jse_pkg::ChU;
					body[2]  = jse_pkg::ChL;
					body[3]  = jse_pkg::ChL;
					body_cnt = 4'd4;
				end
				default: begin
					body[0]  = jse_pkg::ChQuote;
					body_cnt = 4'd1;
				end
			endcase
		end
	end

	// replacement escape goes ahead of the body when a sequence is dropped
	always_comb begin
		if (flush) begin
			plan.chars = {body[5:0], jse_pkg::u16_chars(jse_pkg::CpReplace)};
			plan.count = body_cnt + 4'd6;
		end else begin
			plan.chars = body;
			plan.count = body_cnt;
		end
	end

endmodule

`default_nettype wire

FILE: design/jse_emit.sv
// ----------------------------------------------------------------------------
// jse_emit
// Result register: holds the characters of one item and shifts them out one
// per accepted output, marking the final one with tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_emit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load_req,
	input  wire jse_pkg::plan_t plan,
	output logic                free,
	output logic                m_axis_tvalid,
	input  wire logic           m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // char_out[7:0]
	output logic                m_axis_tlast
);

	jse_pkg::char_vec_t        chars_q;
	logic [jse_pkg::CntW-1:0]  cnt_q;
	logic                      load;
	logic                      take;

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = chars_q[0];
	assign m_axis_tlast  = (cnt_q == jse_pkg::CntW'(1));
	assign take          = m_axis_tvalid && m_axis_tready;

	// empty now, or emptied by this cycle's output
	assign free = (cnt_q == '0) || (m_axis_tlast && m_axis_tready);
	assign load = load_req && free;

	// remaining character count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= plan.count;
		end else if (take) begin
			cnt_q <= cnt_q - jse_pkg::CntW'(1);
		end
	end

	// character shift line
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= plan.chars;
		end else if (take) begin
			chars_q <= {8'h00, chars_q[jse_pkg::MaxOut-1:1]};
		end
	end

endmodule

`default_nettype wire

FILE: design/jse_check.sv
// ----------------------------------------------------------------------------
// jse_check
// Port-level checks for the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	// a stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// an item's characters come without gaps until tlast
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside the characters of one item");

	// the input stalls only behind a waiting character
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no character waiting");

	// a backslash that is not the final character starts an escape
	a_escape_letter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast &&
		m_axis_tdata == jse_pkg::ChBslash |=>
			m_axis_tdata == jse_pkg::ChQuote || m_axis_tdata == jse_pkg::ChBslash ||
			m_axis_tdata == jse_pkg::ChN || m_axis_tdata == jse_pkg::ChR ||
			m_axis_tdata == jse_pkg::ChT || m_axis_tdata == jse_pkg::ChU)
		else $error("backslash not followed by an escape letter");

	// a written register reads back the written bit
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == jse_pkg::RegEscape |=>
			paddr[2] != jse_pkg::RegEscape || prdata == {31'b0, $past(pwdata[0])})
		else $error("configuration read back mismatch");

endmodule

bind json_string_escaper jse_check u_check (.*);

`default_nettype wire
